[src/assert_macros.svh]
// assertion macros used by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/nvis_pkg.sv]
// shared types and constants for the nearest value index search
package nvis_pkg;

    localparam int VAL_W     = 32;
    localparam int OP_W      = 2;
    localparam int RES_IDX_W = 10;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic vld;
        cmd_t cmd;
    } queue_head_t;

endpackage

[src/nearest_value_index_search.sv]
// top level of the nearest value index search
// append: the value is written and the result goes out through S_DONE; clear gives no result
// query: one table read per cycle on the single read port of the table ram sets the
//   pace, one item at a time
// a two-entry queue takes items while the back end searches
// reset clears the entry count, the queue and the result valid flag; table contents are kept
`include "assert_macros.svh"

module nearest_value_index_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  logic [nvis_pkg::OP_W-1:0]             operation,
    input  logic signed [nvis_pkg::VAL_W-1:0]     data_value,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output logic [nvis_pkg::RES_IDX_W-1:0]        nearest_index,
    output logic                                  error_flag
);

    nvis_pkg::queue_head_t head;
    logic                  pop;

    nvis_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .operation  (operation),
        .data_value (data_value),
        .head       (head),
        .pop        (pop)
    );

    nvis_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .nearest_index (nearest_index),
        .error_flag    (error_flag)
    );

    `ASSERT_IMPL(a_pop_needs_item, clk, rst_n, pop, head.vld, "pop from empty queue")
    `ASSERT_IMPL(a_full_not_empty, clk, rst_n, !req_ready, head.vld, "full queue shows no item")
    `ASSERT_IMPL(a_err_idx_zero, clk, rst_n, rsp_valid && error_flag, nearest_index == '0,
        "error result with nonzero index")
    `ASSERT_NEXT(a_pop_advances, clk, rst_n, pop && !(req_valid && req_ready), !pop || head.vld,
        "queue pop without item")

endmodule

[src/nvis_ram.sv]
// generic single write port ram with registered read
module nvis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/nvis_front.sv]
// front end: accepts items, classifies them and queues commands
module nvis_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [nvis_pkg::OP_W-1:0]     operation,
    input  logic signed [nvis_pkg::VAL_W-1:0] data_value,
    output nvis_pkg::queue_head_t         head,
    input  logic                          pop
);

    localparam int QDEPTH = 2;

    nvis_pkg::cmd_t slot_reg [QDEPTH];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    nvis_pkg::cmd_t cmd_c;
    logic           keep_c;
    logic           push_c;

    // unused opcode is taken and dropped
    always_comb
    begin
        cmd_c.value = data_value;
        cmd_c.kind  = nvis_pkg::CMD_CLEAR;
        keep_c      = 1'b1;
        case (operation)
            nvis_pkg::OP_CLEAR:  cmd_c.kind = nvis_pkg::CMD_CLEAR;
            nvis_pkg::OP_APPEND: cmd_c.kind = nvis_pkg::CMD_APPEND;
            nvis_pkg::OP_QUERY:  cmd_c.kind = nvis_pkg::CMD_QUERY;
            default:             keep_c     = 1'b0;
        endcase
    end

    assign req_ready = (cnt_reg != 2'(QDEPTH));
    assign push_c    = req_valid && req_ready && keep_c;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_c)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push_c && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push_c)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_c)
        begin
            slot_reg[wr_ptr_reg] <= cmd_c;
        end
    end

    assign head.vld = (cnt_reg != 2'd0);
    assign head.cmd = slot_reg[rd_ptr_reg];

endmodule

[src/nvis_back.sv]
// back end: table ownership, search sequencer and result register
module nvis_back #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  nvis_pkg::queue_head_t             head,
    output logic                              pop,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic [nvis_pkg::RES_IDX_W-1:0]    nearest_index,
    output logic                              error_flag
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int WIDE_W = IDX_W + nvis_pkg::RES_IDX_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FIRST = 7'b0000010,
        S_LAST  = 7'b0000100,
        S_DBL   = 7'b0001000,
        S_HALF  = 7'b0010000,
        S_CMP   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic signed [31:0] key_reg, key_next;
    logic [IDX_W-1:0]   lo_reg, lo_next;
    logic [IDX_W-1:0]   hi_reg, hi_next;
    logic signed [31:0] vlo_reg, vlo_next;
    logic signed [31:0] vhi_reg, vhi_next;
    logic [IDX_W:0]     prb_reg, prb_next;
    logic [IDX_W-1:0]   res_reg, res_next;
    logic               err_reg, err_next;
    logic               rsp_vld_reg, rsp_vld_next;
    logic [nvis_pkg::RES_IDX_W-1:0] rsp_idx_reg, rsp_idx_next;
    logic               rsp_err_reg, rsp_err_next;

    logic               we_c;
    logic [IDX_W-1:0]   raddr_c;
    logic [31:0]        rdata;
    logic signed [31:0] rd_c;
    logic [WIDE_W-1:0]  wide_idx_c;

    nvis_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we_c),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (head.cmd.value),
        .raddr (raddr_c),
        .rdata (rdata)
    );

    assign rd_c       = $signed(rdata);
    assign wide_idx_c = WIDE_W'(res_reg);

    always_comb
    begin
        logic [IDX_W-1:0]  nlo;
        logic [IDX_W-1:0]  nhi;
        logic [IDX_W:0]    nprb;
        logic [IDX_W:0]    sum;
        logic              dbl;
        logic              step;
        logic signed [32:0] dlo;
        logic signed [32:0] dhi;

        state_next   = state_reg;
        count_next   = count_reg;
        key_next     = key_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        vlo_next     = vlo_reg;
        vhi_next     = vhi_reg;
        prb_next     = prb_reg;
        res_next     = res_reg;
        err_next     = err_reg;
        rsp_vld_next = rsp_vld_reg;
        rsp_idx_next = rsp_idx_reg;
        rsp_err_next = rsp_err_reg;
        pop          = 1'b0;
        we_c         = 1'b0;
        raddr_c      = '0;
        nlo          = lo_reg;
        nhi          = hi_reg;
        nprb         = prb_reg;
        sum          = '0;
        dbl          = 1'b0;
        step         = 1'b0;
        dlo          = {key_reg[31], key_reg} - {vlo_reg[31], vlo_reg};
        dhi          = {vhi_reg[31], vhi_reg} - {key_reg[31], key_reg};

        if (rsp_vld_reg && rsp_ready)
        begin
            rsp_vld_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (head.vld)
                begin
                    pop = 1'b1;
                    case (head.cmd.kind)
                        nvis_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        nvis_pkg::CMD_APPEND:
                        begin
                            res_next   = '0;
                            state_next = S_DONE;
                            if (count_reg < CNT_W'(TABLE_DEPTH))
                            begin
                                we_c       = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                err_next   = 1'b0;
                            end
                            else
                            begin
                                err_next = 1'b1;
                            end
                        end
                        nvis_pkg::CMD_QUERY:
                        begin
                            key_next = head.cmd.value;
                            lo_next  = '0;
                            hi_next  = IDX_W'(count_reg - CNT_W'(1));
                            res_next = '0;
                            if (count_reg == '0)
                            begin
                                err_next   = 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                err_next   = 1'b0;
                                state_next = S_FIRST;
                            end
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            S_FIRST:
            begin
                if (key_reg <= rd_c)
                begin
                    res_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    vlo_next   = rd_c;
                    raddr_c    = hi_reg;
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                if (key_reg >= rd_c)
                begin
                    res_next   = hi_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    vhi_next = rd_c;
                    nprb     = (IDX_W+1)'(1);
                    dbl      = 1'b1;
                    step     = 1'b1;
                end
            end
            S_DBL, S_HALF:
            begin
                if (rd_c < key_reg)
                begin
                    nlo      = prb_reg[IDX_W-1:0];
                    vlo_next = rd_c;
                end
                else
                begin
                    nhi      = prb_reg[IDX_W-1:0];
                    vhi_next = rd_c;
                end
                nprb = prb_reg << 1;
                dbl  = (state_reg == S_DBL);
                step = 1'b1;
            end
            S_CMP:
            begin
                res_next   = (dlo > dhi) ? hi_reg : lo_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_vld_reg || rsp_ready)
                begin
                    rsp_vld_next = 1'b1;
                    rsp_idx_next = wide_idx_c[nvis_pkg::RES_IDX_W-1:0];
                    rsp_err_next = err_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // pick the next probe: keep doubling, else halve, else compare
        if (step)
        begin
            lo_next = nlo;
            hi_next = nhi;
            sum     = {1'b0, nlo} + {1'b0, nhi};
            if (dbl && (nprb < {1'b0, nhi}))
            begin
                raddr_c    = nprb[IDX_W-1:0];
                prb_next   = nprb;
                state_next = S_DBL;
            end
            else if (({1'b0, nlo} + (IDX_W+1)'(1)) < {1'b0, nhi})
            begin
                raddr_c    = sum[IDX_W:1];
                prb_next   = {1'b0, sum[IDX_W:1]};
                state_next = S_HALF;
            end
            else
            begin
                state_next = S_CMP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        vlo_reg     <= vlo_next;
        vhi_reg     <= vhi_next;
        prb_reg     <= prb_next;
        res_reg     <= res_next;
        err_reg     <= err_next;
        rsp_idx_reg <= rsp_idx_next;
        rsp_err_reg <= rsp_err_next;
    end

    assign rsp_valid     = rsp_vld_reg;
    assign nearest_index = rsp_idx_reg;
    assign error_flag    = rsp_err_reg;

endmodule
